// File: sv/mepg_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse point generator package
// Shared codes and the command and status types between controller and
// datapath.
// ----------------------------------------------------------------------------
package mepg_pkg;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } req_cmd_type;

   typedef enum logic [3:0] {
      OP_NONE    = 4'd0,
      OP_LOAD    = 4'd1,
      OP_EMIT    = 4'd2,
      OP_INIT_A  = 4'd3,
      OP_INIT_B  = 4'd4,
      OP_INIT_C  = 4'd5,
      OP_ADVANCE = 4'd6,
      OP_R2_A    = 4'd7,
      OP_R2_B    = 4'd8,
      OP_R2_C    = 4'd9,
      OP_R2_D    = 4'd10
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic quad_last;
      logic last_point;
      logic in_second_region;
      logic px_lt_py;
   } dp_status_type;

endpackage

// File: sv/mepg_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying start and step commands with ellipse geometry.
// ----------------------------------------------------------------------------
interface mepg_req_if #(
   parameter int COORD_BITS  = 16,
   parameter int RADIUS_BITS = 12
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [COORD_BITS-1:0]  center_x;
   logic signed [COORD_BITS-1:0]  center_y;
   logic        [RADIUS_BITS-1:0] radius_x;
   logic        [RADIUS_BITS-1:0] radius_y;

   modport source (output valid, cmd, center_x, center_y, radius_x, radius_y,
                   input ready);
   modport sink (input valid, cmd, center_x, center_y, radius_x, radius_y,
                 output ready);
endinterface

// File: sv/mepg_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one outline point per item.
// ----------------------------------------------------------------------------
interface mepg_rsp_if #(
   parameter int COORD_BITS = 16
);
   logic                        valid;
   logic                        ready;
   logic signed [COORD_BITS:0]  point_x;
   logic signed [COORD_BITS:0]  point_y;
   logic                        last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

// File: sv/mepg_datapath.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse datapath
// Holds the walk state, runs the setup and region-change products in their
// own sequenced steps, applies the per-iteration update and forms mirrored points.
// ----------------------------------------------------------------------------
module mepg_datapath #(
   parameter int RADIUS_BITS = 12,
   parameter int COORD_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mepg_pkg::dp_cmd_type          cmd,
   output mepg_pkg::dp_status_type       status,
   input  logic signed [COORD_BITS-1:0]  req_center_x,
   input  logic signed [COORD_BITS-1:0]  req_center_y,
   input  logic        [RADIUS_BITS-1:0] req_radius_x,
   input  logic        [RADIUS_BITS-1:0] req_radius_y,
   output logic signed [COORD_BITS:0]    rsp_point_x,
   output logic signed [COORD_BITS:0]    rsp_point_y,
   output logic                          rsp_last_point
);

   localparam int RB   = RADIUS_BITS;
   localparam int CB   = COORD_BITS;
   localparam int OXW  = RB + 1;
   localparam int OYW  = RB + 2;
   localparam int SQW  = 2 * RB;
   localparam int PRW  = 3 * RB;
   localparam int SLW  = 3 * RB + 2;
   localparam int DCW  = 4 * RB;
   localparam int M1W  = 2 * RB + 2;
   localparam int SQ2W = 4 * RB + 4;
   localparam int DFW  = 2 * RB + 1;
   localparam int P2W  = 4 * RB + 2;
   localparam int OUTW = CB + 1;
   localparam int SUMW = ((CB > RB + 2) ? CB : RB + 2) + 1;

   logic signed [CB-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic        [RB-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic        [SQW-1:0]  rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic        [PRW-1:0]  prod_ff, prod_in;
   logic        [OXW-1:0]  offx_ff, offx_in;
   logic signed [OYW-1:0]  offy_ff, offy_in;
   logic signed [SLW-1:0]  px_ff, px_in, py_ff, py_in;
   logic signed [DCW-1:0]  dec_ff, dec_in;
   logic                   in_r2_ff, in_r2_in;
   logic        [1:0]      quad_ff, quad_in;
   logic        [M1W-1:0]  m1_ff, m1_in;
   logic        [SQW-1:0]  yy_ff, yy_in;
   logic        [SQ2W-1:0] sq_ff, sq_in;
   logic signed [DFW-1:0]  diff_ff, diff_in;
   logic signed [P2W-1:0]  p2_ff, p2_in;
   logic signed [OUTW-1:0] point_x_ff, point_x_in, point_y_ff, point_y_in;
   logic                   last_ff, last_in;

   logic signed [SLW-1:0]   two_rx2, two_ry2, px_step, py_step;
   logic signed [DCW-1:0]   rx2_d, ry2_d, prod_d, rx2_q_d, px_step_d, py_step_d;
   logic        [OYW-1:0]   t_val;
   logic signed [OYW-1:0]   ym;
   logic signed [2*OYW-1:0] yy_full;
   logic signed [SUMW-1:0]  cx_ext, cy_ext, ox_ext, oy_ext, sum_x, sum_y;
   logic                    last_now;

   assign two_rx2   = $signed({{(SLW-SQW-1){1'b0}}, rx2_ff, 1'b0});
   assign two_ry2   = $signed({{(SLW-SQW-1){1'b0}}, ry2_ff, 1'b0});
   assign px_step   = px_ff + two_ry2;
   assign py_step   = py_ff - two_rx2;
   assign rx2_d     = $signed({{(DCW-SQW){1'b0}}, rx2_ff});
   assign ry2_d     = $signed({{(DCW-SQW){1'b0}}, ry2_ff});
   assign prod_d    = $signed({{(DCW-PRW){1'b0}}, prod_ff});
   assign rx2_q_d   = $signed({{(DCW-SQW+2){1'b0}}, rx2_ff[SQW-1:2]});
   assign px_step_d = $signed({{(DCW-SLW){px_step[SLW-1]}}, px_step});
   assign py_step_d = $signed({{(DCW-SLW){py_step[SLW-1]}}, py_step});
   assign t_val     = {offx_ff, 1'b1};
   assign ym        = offy_ff - OYW'(1);
   assign yy_full   = ym * ym;

   assign cx_ext = $signed({{(SUMW-CB){cx_ff[CB-1]}}, cx_ff});
   assign cy_ext = $signed({{(SUMW-CB){cy_ff[CB-1]}}, cy_ff});
   assign ox_ext = $signed({{(SUMW-OXW){1'b0}}, offx_ff});
   assign oy_ext = $signed({{(SUMW-OYW){offy_ff[OYW-1]}}, offy_ff});
   assign sum_x  = quad_ff[0] ? (cx_ext - ox_ext) : (cx_ext + ox_ext);
   assign sum_y  = quad_ff[1] ? (cy_ext - oy_ext) : (cy_ext + oy_ext);

   assign last_now = in_r2_ff && (quad_ff == 2'd3) &&
                     (offy_ff[OYW-1] || (offy_ff == '0));

   assign status.quad_last        = (quad_ff == 2'd3);
   assign status.last_point       = last_now;
   assign status.in_second_region = in_r2_ff;
   assign status.px_lt_py         = (px_ff < py_ff);

   assign rsp_point_x    = point_x_ff;
   assign rsp_point_y    = point_y_ff;
   assign rsp_last_point = last_ff;

   always_comb begin
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      rx_in      = rx_ff;
      ry_in      = ry_ff;
      rx2_in     = rx2_ff;
      ry2_in     = ry2_ff;
      prod_in    = prod_ff;
      offx_in    = offx_ff;
      offy_in    = offy_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      dec_in     = dec_ff;
      in_r2_in   = in_r2_ff;
      quad_in    = quad_ff;
      m1_in      = m1_ff;
      yy_in      = yy_ff;
      sq_in      = sq_ff;
      diff_in    = diff_ff;
      p2_in      = p2_ff;
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      last_in    = last_ff;
      unique case (cmd.op)
         mepg_pkg::OP_LOAD: begin
            cx_in    = req_center_x;
            cy_in    = req_center_y;
            rx_in    = req_radius_x;
            ry_in    = req_radius_y;
            offx_in  = '0;
            offy_in  = $signed({2'b00, req_radius_y});
            px_in    = '0;
            in_r2_in = 1'b0;
            quad_in  = 2'd0;
         end
         mepg_pkg::OP_EMIT: begin
            point_x_in = sum_x[OUTW-1:0];
            point_y_in = sum_y[OUTW-1:0];
            last_in    = last_now;
            quad_in    = quad_ff + 2'd1;
         end
         mepg_pkg::OP_INIT_A: begin
            rx2_in = rx_ff * rx_ff;
            ry2_in = ry_ff * ry_ff;
         end
         mepg_pkg::OP_INIT_B: begin
            prod_in = rx2_ff * ry_ff;
         end
         mepg_pkg::OP_INIT_C: begin
            py_in  = $signed({{(SLW-PRW-1){1'b0}}, prod_ff, 1'b0});
            dec_in = ry2_d - prod_d + rx2_q_d;
         end
         mepg_pkg::OP_ADVANCE: begin
            if (!in_r2_ff) begin
               offx_in = offx_ff + OXW'(1);
               px_in   = px_step;
               if (dec_ff[DCW-1]) begin
                  dec_in = dec_ff + ry2_d + px_step_d;
               end else begin
                  offy_in = offy_ff - OYW'(1);
                  py_in   = py_step;
                  dec_in  = dec_ff + ry2_d + px_step_d - py_step_d;
               end
            end else begin
               offy_in = offy_ff - OYW'(1);
               py_in   = py_step;
               if (!dec_ff[DCW-1] && (dec_ff != '0)) begin
                  dec_in = dec_ff + rx2_d - py_step_d;
               end else begin
                  offx_in = offx_ff + OXW'(1);
                  px_in   = px_step;
                  dec_in  = dec_ff + rx2_d - py_step_d + px_step_d;
               end
            end
         end
         mepg_pkg::OP_R2_A: begin
            m1_in = ry_ff * t_val;
            yy_in = yy_full[SQW-1:0];
         end
         mepg_pkg::OP_R2_B: begin
            sq_in   = m1_ff * m1_ff;
            diff_in = $signed({1'b0, yy_ff}) - $signed({1'b0, ry2_ff});
         end
         mepg_pkg::OP_R2_C: begin
            p2_in = $signed({1'b0, rx2_ff}) * diff_ff;
         end
         mepg_pkg::OP_R2_D: begin
            dec_in   = $signed(sq_ff[DCW+1:2]) + $signed(p2_ff[DCW-1:0]);
            in_r2_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_r2_ff <= 1'b0;
         quad_ff  <= 2'd0;
      end else begin
         in_r2_ff <= in_r2_in;
         quad_ff  <= quad_in;
      end
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      rx2_ff     <= rx2_in;
      ry2_ff     <= ry2_in;
      prod_ff    <= prod_in;
      offx_ff    <= offx_in;
      offy_ff    <= offy_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      dec_ff     <= dec_in;
      m1_ff      <= m1_in;
      yy_ff      <= yy_in;
      sq_ff      <= sq_in;
      diff_ff    <= diff_in;
      p2_ff      <= p2_in;
      point_x_ff <= point_x_in;
      point_y_ff <= point_y_in;
      last_ff    <= last_in;
   end

endmodule

// File: sv/mepg_controller.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse controller
// Sequences setup, per-iteration update and region change, and owns the
// request and response handshakes.
// ----------------------------------------------------------------------------
module mepg_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_cmd,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mepg_pkg::dp_status_type status,
   output mepg_pkg::dp_cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_WALK   = 11'b000_0000_0010,
      S_INIT_A = 11'b000_0000_0100,
      S_INIT_B = 11'b000_0000_1000,
      S_INIT_C = 11'b000_0001_0000,
      S_CHK    = 11'b000_0010_0000,
      S_ADV    = 11'b000_0100_0000,
      S_R2_A   = 11'b000_1000_0000,
      S_R2_B   = 11'b001_0000_0000,
      S_R2_C   = 11'b010_0000_0000,
      S_R2_D   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free, req_fire, is_step;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = ((state_ff == S_IDLE) || (state_ff == S_WALK)) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign is_step   = (req_cmd == mepg_pkg::CMD_STEP);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd.op   = mepg_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && !is_step) begin
               cmd.op   = mepg_pkg::OP_LOAD;
               state_in = S_INIT_A;
            end
         end
         S_WALK: begin
            if (req_fire) begin
               if (!is_step) begin
                  cmd.op   = mepg_pkg::OP_LOAD;
                  state_in = S_INIT_A;
               end else begin
                  cmd.op = mepg_pkg::OP_EMIT;
                  if (status.quad_last) begin
                     state_in = status.last_point ? S_IDLE : S_ADV;
                  end
               end
            end
         end
         S_INIT_A: begin
            cmd.op   = mepg_pkg::OP_INIT_A;
            state_in = S_INIT_B;
         end
         S_INIT_B: begin
            cmd.op   = mepg_pkg::OP_INIT_B;
            state_in = S_INIT_C;
         end
         S_INIT_C: begin
            cmd.op   = mepg_pkg::OP_INIT_C;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (!status.in_second_region && !status.px_lt_py) begin
               state_in = S_R2_A;
            end else begin
               state_in = S_WALK;
            end
         end
         S_ADV: begin
            cmd.op   = mepg_pkg::OP_ADVANCE;
            state_in = S_CHK;
         end
         S_R2_A: begin
            cmd.op   = mepg_pkg::OP_R2_A;
            state_in = S_R2_B;
         end
         S_R2_B: begin
            cmd.op   = mepg_pkg::OP_R2_B;
            state_in = S_R2_C;
         end
         S_R2_C: begin
            cmd.op   = mepg_pkg::OP_R2_C;
            state_in = S_R2_D;
         end
         S_R2_D: begin
            cmd.op   = mepg_pkg::OP_R2_D;
            state_in = S_WALK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.op == mepg_pkg::OP_EMIT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && req_fire && is_step && status.last_point)
      |=> (state_ff == S_IDLE))
      else $error("walk did not end after last point");

   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire && is_step && (state_ff == S_WALK)))
      else $error("response raised without a step");

   a_adv_to_chk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADV) |=> (state_ff == S_CHK))
      else $error("advance not followed by region check");

   a_r2_from_chk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_R2_A) |-> $past(state_ff == S_CHK && !status.in_second_region))
      else $error("region change not entered from region check");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (state_ff == S_IDLE || state_ff == S_WALK))
      else $error("item accepted during setup or update");
`endif

endmodule

// File: sv/midpoint_ellipse_point_generator.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse point generator
// Walks an ellipse outline with the midpoint method and emits one mirrored
// point per step command.
//
//   Channel | Direction | Payload
//   req_if  | in        | cmd, center_x, center_y, radius_x, radius_y
//   rsp_if  | out       | point_x, point_y, last_point
//
// A step emits one point; every fourth step, unless it ends the walk, also
// runs the update and region check, and then the region change if needed.
// A start loads the request, forms the setup products and runs the check,
// plus the region change when the walk opens in the second region.
// Reset is synchronous and returns the block to idle with no result pending.
// One output register holds a point; a step waits while it is full and not
// taken.
// ----------------------------------------------------------------------------
module midpoint_ellipse_point_generator #(
   parameter int RADIUS_BITS = 12,
   parameter int COORD_BITS  = 16
) (
   input logic       clock,
   input logic       reset,
   mepg_req_if.sink  req_if,
   mepg_rsp_if.source rsp_if
);

   mepg_pkg::dp_cmd_type    dp_cmd;
   mepg_pkg::dp_status_type dp_status;

   mepg_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_cmd   (req_if.cmd),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   mepg_datapath #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .req_center_x   (req_if.center_x),
      .req_center_y   (req_if.center_y),
      .req_radius_x   (req_if.radius_x),
      .req_radius_y   (req_if.radius_y),
      .rsp_point_x    (rsp_if.point_x),
      .rsp_point_y    (rsp_if.point_y),
      .rsp_last_point (rsp_if.last_point)
   );

endmodule
